// ----- sv/rlp_hdr_pkg.sv -----
// Package for the RLP header length decoder.
// Field widths, prefix class boundaries and the result beat type.
// No dependencies.
package rlp_hdr_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned LENGTH_W    = 32;
  localparam int unsigned HDR_SIZE_W  = 3;
  localparam int unsigned LEN_LEFT_W  = 3;

  // Prefix class boundaries.
  localparam logic [DATA_W-1:0] SINGLE_MAX      = 8'h7f;
  localparam logic [DATA_W-1:0] SHORT_STR_BASE  = 8'h80;
  localparam logic [DATA_W-1:0] SHORT_STR_MAX   = 8'hb7;
  localparam logic [DATA_W-1:0] LONG_STR_MAX    = 8'hbb;
  localparam logic [DATA_W-1:0] STR_MAX         = 8'hbf;
  localparam logic [DATA_W-1:0] SHORT_LIST_BASE = 8'hc0;
  localparam logic [DATA_W-1:0] SHORT_LIST_MAX  = 8'hf7;
  localparam logic [DATA_W-1:0] LONG_LIST_MAX   = 8'hfb;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_TOO_LONG = 1'b1
  } status_t;

  typedef struct packed {
    logic [LENGTH_W-1:0]   field_length;
    logic [HDR_SIZE_W-1:0] header_size;
    logic                  is_list;
    status_t               status;
  } result_t;

endpackage

// ----- sv/rlp_hdr_in_if.sv -----
// Input byte channel of the RLP header length decoder.
// Valid/ready handshake with data_byte and field_start; uses rlp_hdr_pkg.
interface rlp_hdr_in_if
  import rlp_hdr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              field_start;

  modport source (output valid, output data_byte, output field_start, input ready);
  modport sink (input valid, input data_byte, input field_start, output ready);
endinterface

// ----- sv/rlp_hdr_out_if.sv -----
// Result channel of the RLP header length decoder.
// Valid/ready handshake with the decoded header fields; uses rlp_hdr_pkg.
interface rlp_hdr_out_if
  import rlp_hdr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [LENGTH_W-1:0]   field_length;
  logic [HDR_SIZE_W-1:0] header_size;
  logic                  is_list;
  logic                  status;

  modport source (
    output valid, output field_length, output header_size, output is_list,
    output status, input ready
  );
  modport sink (
    input valid, input field_length, input header_size, input is_list,
    input status, output ready
  );
endinterface

// ----- sv/rlp_header_length_decoder.sv -----
// RLP header length decoder: classifies prefix bytes and collects long lengths.
// Depends on rlp_hdr_pkg, rlp_hdr_in_if and rlp_hdr_out_if.
//
// Usage: bytes of an RLP stream enter on byte_stream, one per beat, with
// field_start set on the prefix byte of each field. Decoded headers leave on
// result: field length, header size, list flag and status. A single-value,
// short or too-long prefix gives a result beat by itself; a long string or
// list gives its beat on the last of its 1 to 4 length bytes. Payload bytes
// (no start flag, nothing being collected) give no beat. A start flag during
// collection drops the partial header.
// Throughput: one byte per cycle while result is not stalled. A byte is
// registered in the input register, then decoded against the header state,
// and its result is registered in the result register, from which the
// result beat is taken.
// Reset (rst, synchronous) empties both register stages and clears the header
// state. When the receiver stalls, the result register holds its beat; if
// the input register is empty it takes one more byte, then byte_stream.ready drops.
module rlp_header_length_decoder
  import rlp_hdr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rlp_hdr_in_if.sink    byte_stream,
  rlp_hdr_out_if.source result
);

  // Input register
  logic              in_valid;
  logic [DATA_W-1:0] in_byte;
  logic              in_start;

  // Header state
  logic                  collecting;
  logic [LEN_LEFT_W-1:0] length_bytes_left;
  logic [LENGTH_W-1:0]   length_accumulator;
  logic [HDR_SIZE_W-1:0] pending_header_size;
  logic                  pending_is_list;

  // Result register
  logic    out_valid;
  result_t out_beat;

  logic advance;
  logic step;

  logic                  collecting_next;
  logic [LEN_LEFT_W-1:0] length_bytes_left_next;
  logic [LENGTH_W-1:0]   length_accumulator_next;
  logic [HDR_SIZE_W-1:0] pending_header_size_next;
  logic                  pending_is_list_next;
  logic                  emit;
  result_t               beat_next;
  logic [LEN_LEFT_W-1:0] len_count;

  assign advance           = !out_valid || result.ready;
  assign step              = in_valid && advance;
  assign byte_stream.ready = !in_valid || advance;

  assign len_count = {1'b0, in_byte[1:0]} + LEN_LEFT_W'(1);

  always_comb begin
    collecting_next          = collecting;
    length_bytes_left_next   = length_bytes_left;
    length_accumulator_next  = length_accumulator;
    pending_header_size_next = pending_header_size;
    pending_is_list_next     = pending_is_list;
    emit                     = 1'b0;
    beat_next.field_length   = '0;
    beat_next.header_size    = '0;
    beat_next.is_list        = 1'b0;
    beat_next.status         = STATUS_OK;
    if (in_start) begin
      collecting_next         = 1'b0;
      length_bytes_left_next  = '0;
      length_accumulator_next = '0;
      emit                    = 1'b1;
      priority if (in_byte <= SINGLE_MAX) begin
        beat_next.field_length = LENGTH_W'(1);
      end else if (in_byte <= SHORT_STR_MAX) begin
        beat_next.field_length = LENGTH_W'(in_byte - SHORT_STR_BASE);
        beat_next.header_size  = HDR_SIZE_W'(1);
      end else if (in_byte <= LONG_STR_MAX ||
                   (in_byte > SHORT_LIST_MAX && in_byte <= LONG_LIST_MAX)) begin
        emit                     = 1'b0;
        collecting_next          = 1'b1;
        length_bytes_left_next   = len_count;
        pending_header_size_next = len_count + HDR_SIZE_W'(1);
        pending_is_list_next     = in_byte > SHORT_LIST_MAX;
      end else if (in_byte <= STR_MAX) begin
        beat_next.status = STATUS_TOO_LONG;
      end else if (in_byte <= SHORT_LIST_MAX) begin
        beat_next.field_length = LENGTH_W'(in_byte - SHORT_LIST_BASE);
        beat_next.header_size  = HDR_SIZE_W'(1);
        beat_next.is_list      = 1'b1;
      end else begin
        beat_next.is_list = 1'b1;
        beat_next.status  = STATUS_TOO_LONG;
      end
    end else if (collecting) begin
      length_accumulator_next = {length_accumulator[LENGTH_W-DATA_W-1:0], in_byte};
      length_bytes_left_next  = length_bytes_left - LEN_LEFT_W'(1);
      if (length_bytes_left_next == '0) begin
        collecting_next        = 1'b0;
        emit                   = 1'b1;
        beat_next.field_length = length_accumulator_next;
        beat_next.header_size  = pending_header_size;
        beat_next.is_list      = pending_is_list;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid            <= 1'b0;
      out_valid           <= 1'b0;
      collecting          <= 1'b0;
      length_bytes_left   <= '0;
      length_accumulator  <= '0;
      pending_header_size <= '0;
      pending_is_list     <= 1'b0;
    end else begin
      if (byte_stream.ready) begin
        in_valid <= byte_stream.valid;
      end
      if (advance) begin
        out_valid <= step && emit;
      end
      if (step) begin
        collecting          <= collecting_next;
        length_bytes_left   <= length_bytes_left_next;
        length_accumulator  <= length_accumulator_next;
        pending_header_size <= pending_header_size_next;
        pending_is_list     <= pending_is_list_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.ready && byte_stream.valid) begin
      in_byte  <= byte_stream.data_byte;
      in_start <= byte_stream.field_start;
    end
    if (step && emit) begin
      out_beat <= beat_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.field_length = out_beat.field_length;
  assign result.header_size  = out_beat.header_size;
  assign result.is_list      = out_beat.is_list;
  assign result.status       = out_beat.status;

endmodule
